// File: src/clt_pkg.sv
// clt_pkg: shared types and constants for the command line tokenizer.
// Holds the item structs, result kind codes and the split plan passed
// between the parse stage and the result sequencer. No dependencies.
`timescale 1ns / 1ps

package clt_pkg;

  localparam int MAX_PEND_DEF = 32;
  localparam int MAX_ARGS_DEF = 256;

  // Fixed by the state widths: pending count and argument number.
  localparam int PEND_W = 6;
  localparam int ARG_W  = 8;

  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] CH_TAB       = 8'h09;

  typedef enum logic [1:0] {
    KIND_BYTE = 2'd0,
    KIND_END  = 2'd1,
    KIND_OVF  = 2'd2
  } kind_t;

  typedef struct packed {
    logic [7:0] char_in;
    logic       end_of_line;
  } in_item_t;

  typedef struct packed {
    kind_t            kind;
    logic [7:0]       char_out;
    logic [ARG_W-1:0] arg_index;
    logic             last_of_run;
  } out_item_t;

  // Results of one input item, in order: n_a backslashes, optional t1,
  // n_b backslashes, optional end mark. All share one argument number.
  typedef struct packed {
    logic [PEND_W-1:0] n_a;
    logic              t1_v;
    kind_t             t1_kind;
    logic [7:0]        t1_char;
    logic [PEND_W-1:0] n_b;
    logic              t2_v;
    logic [ARG_W-1:0]  arg_index;
  } plan_t;

endpackage

// File: src/clt_parse.sv
// clt_parse: input register, splitter state and the per-byte split rules.
// Turns each item into a plan_t for clt_emit. Depends on clt_pkg.
`timescale 1ns / 1ps

module clt_parse #(
  parameter int MAX_PENDING_BACKSLASHES = clt_pkg::MAX_PEND_DEF,
  parameter int MAX_ARGUMENTS           = clt_pkg::MAX_ARGS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  clt_pkg::in_item_t in_item,
  output logic              plan_valid,
  output clt_pkg::plan_t    plan,
  input  logic              plan_take
);
  import clt_pkg::*;

  localparam logic [PEND_W-1:0] PEND_MAX = PEND_W'(MAX_PENDING_BACKSLASHES);
  localparam logic [ARG_W-1:0]  ARG_MAX  = ARG_W'(MAX_ARGUMENTS - 1);

  typedef enum logic [2:0] {
    PH_START = 3'd0,
    PH_QPATH = 3'd1,
    PH_BPATH = 3'd2,
    PH_GAP   = 3'd3,
    PH_ARG   = 3'd4
  } phase_t;

  in_item_t          item_r;
  logic              item_v_r;
  phase_t            phase_r, phase_nxt;
  logic [1:0]        qc_r, qc_nxt;
  logic [PEND_W-1:0] pend_r, pend_nxt;
  logic              iqr_r, iqr_nxt;
  logic [ARG_W-1:0]  argn_r, argn_nxt;

  logic [7:0]        c;
  logic              blank;
  logic              plan_empty;
  logic              advance;

  assign c     = item_r.char_in;
  assign blank = (c == CH_SPACE) || (c == CH_TAB);

  always_comb begin
    logic              do_arg;
    logic [1:0]        qc_w;
    logic [PEND_W-1:0] pend_w;
    logic              iqr_w;

    do_arg    = 1'b0;
    plan      = '0;
    plan.t1_kind = KIND_BYTE;
    phase_nxt = phase_r;
    argn_nxt  = argn_r;
    qc_w      = qc_r;
    pend_w    = pend_r;
    iqr_w     = iqr_r;

    case (phase_r)
      PH_QPATH: begin
        plan.t1_v = 1'b1;
        if (c == CH_QUOTE) begin
          plan.t1_kind = KIND_END;
          phase_nxt    = PH_GAP;
        end else begin
          plan.t1_char = c;
        end
      end
      PH_BPATH: begin
        plan.t1_v = 1'b1;
        if (blank) begin
          plan.t1_kind = KIND_END;
          phase_nxt    = PH_GAP;
        end else begin
          plan.t1_char = c;
        end
      end
      PH_GAP: begin
        if (!blank) begin
          if (argn_r < ARG_MAX) argn_nxt = argn_r + 1'b1;
          qc_w      = '0;
          pend_w    = '0;
          iqr_w     = 1'b0;
          phase_nxt = PH_ARG;
          do_arg    = 1'b1;
        end
      end
      PH_ARG: begin
        do_arg = 1'b1;
      end
      default: begin
        // start of the program path; stray codes behave the same
        argn_nxt = '0;
        if (c == CH_QUOTE) begin
          phase_nxt = PH_QPATH;
        end else if (blank) begin
          plan.t1_v    = 1'b1;
          plan.t1_kind = KIND_END;
          phase_nxt    = PH_GAP;
        end else begin
          plan.t1_v    = 1'b1;
          plan.t1_char = c;
          phase_nxt    = PH_BPATH;
        end
      end
    endcase

    if (do_arg) begin
      if (iqr_w && c != CH_QUOTE) begin
        iqr_w = 1'b0;
        if (qc_w == 2'd2) qc_w = 2'd0;
      end
      if (blank && qc_w == 2'd0) begin
        plan.n_a     = pend_w;
        pend_w       = '0;
        plan.t1_v    = 1'b1;
        plan.t1_kind = KIND_END;
        phase_nxt    = PH_GAP;
      end else if (c == CH_BACKSLASH) begin
        if (pend_w >= PEND_MAX) begin
          pend_w       = PEND_MAX;
          plan.t1_v    = 1'b1;
          plan.t1_kind = KIND_OVF;
        end else begin
          pend_w = pend_w + 1'b1;
        end
      end else if (c == CH_QUOTE) begin
        if (!iqr_w) begin
          plan.n_a = pend_w >> 1;
          if (!pend_w[0]) begin
            qc_w = qc_w + 2'd1;
          end else begin
            plan.t1_v    = 1'b1;
            plan.t1_char = CH_QUOTE;
          end
          pend_w = '0;
          iqr_w  = 1'b1;
        end else begin
          qc_w = qc_w + 2'd1;
          if (qc_w == 2'd3) begin
            plan.t1_v    = 1'b1;
            plan.t1_char = CH_QUOTE;
            qc_w         = 2'd0;
          end
        end
      end else begin
        plan.n_a     = pend_w;
        pend_w       = '0;
        plan.t1_v    = 1'b1;
        plan.t1_char = c;
      end
    end

    plan.arg_index = argn_nxt;
    qc_nxt   = qc_w;
    pend_nxt = pend_w;
    iqr_nxt  = iqr_w;

    // end of line: flush what is held, close the open argument, start over
    if (item_r.end_of_line) begin
      if (phase_nxt == PH_QPATH || phase_nxt == PH_BPATH) begin
        plan.t2_v = 1'b1;
      end else if (phase_nxt == PH_ARG) begin
        plan.n_b  = pend_w;
        plan.t2_v = 1'b1;
      end
      phase_nxt = PH_START;
      qc_nxt    = '0;
      pend_nxt  = '0;
      iqr_nxt   = 1'b0;
      argn_nxt  = '0;
    end
  end

  assign plan_empty = (plan.n_a == '0) && !plan.t1_v && (plan.n_b == '0) && !plan.t2_v;
  assign advance    = item_v_r && (plan_empty || plan_take);
  assign plan_valid = item_v_r && !plan_empty;
  assign in_stall   = item_v_r && !advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_v_r <= 1'b0;
      phase_r  <= PH_START;
      qc_r     <= '0;
      pend_r   <= '0;
      iqr_r    <= 1'b0;
      argn_r   <= '0;
    end else begin
      if (in_valid && !in_stall) begin
        item_r   <= in_item;
        item_v_r <= 1'b1;
      end else if (advance) begin
        item_v_r <= 1'b0;
      end
      if (advance) begin
        phase_r <= phase_nxt;
        qc_r    <= qc_nxt;
        pend_r  <= pend_nxt;
        iqr_r   <= iqr_nxt;
        argn_r  <= argn_nxt;
      end
    end
  end

  a_pend_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r <= PEND_MAX)
    else $error("pending backslash count above its limit");

  a_argn_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    argn_r <= ARG_MAX)
    else $error("argument number beyond saturation");

  a_eol_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && item_r.end_of_line) |=>
      (phase_r == PH_START && qc_r == 2'd0 && pend_r == '0 && argn_r == '0))
    else $error("state not cleared after end of line");

endmodule

// File: src/clt_emit.sv
// clt_emit: expands one plan_t into a run of results, one per cycle unless
// out_stall holds it, into the output register. Depends on clt_pkg.
`timescale 1ns / 1ps

module clt_emit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               plan_valid,
  input  clt_pkg::plan_t     plan,
  output logic               plan_take,
  output logic               out_valid,
  input  logic               out_stall,
  output clt_pkg::out_item_t out_item
);
  import clt_pkg::*;

  logic              busy_r;
  logic [PEND_W-1:0] na_r, na_nxt;
  logic              t1v_r, t1v_nxt;
  kind_t             t1k_r;
  logic [7:0]        t1c_r;
  logic [PEND_W-1:0] nb_r, nb_nxt;
  logic              t2v_r, t2v_nxt;
  logic [ARG_W-1:0]  arg_r;

  logic              out_valid_r;
  out_item_t         out_item_r;
  out_item_t         res;
  logic              slot_free;
  logic              emit_now;
  logic              last;

  assign slot_free = !out_valid_r || !out_stall;
  assign emit_now  = busy_r && slot_free;

  always_comb begin
    na_nxt  = na_r;
    t1v_nxt = t1v_r;
    nb_nxt  = nb_r;
    t2v_nxt = t2v_r;
    res           = '0;
    res.kind      = KIND_BYTE;
    res.arg_index = arg_r;
    if (na_r != '0) begin
      res.char_out = CH_BACKSLASH;
      na_nxt       = na_r - 1'b1;
    end else if (t1v_r) begin
      res.kind     = t1k_r;
      res.char_out = (t1k_r == KIND_BYTE) ? t1c_r : 8'h00;
      t1v_nxt      = 1'b0;
    end else if (nb_r != '0) begin
      res.char_out = CH_BACKSLASH;
      nb_nxt       = nb_r - 1'b1;
    end else begin
      res.kind = KIND_END;
      t2v_nxt  = 1'b0;
    end
    last = (na_nxt == '0) && !t1v_nxt && (nb_nxt == '0) && !t2v_nxt;
    res.last_of_run = last;
  end

  assign plan_take = !busy_r || (emit_now && last);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (plan_take && plan_valid) begin
        busy_r <= 1'b1;
        na_r   <= plan.n_a;
        t1v_r  <= plan.t1_v;
        t1k_r  <= plan.t1_kind;
        t1c_r  <= plan.t1_char;
        nb_r   <= plan.n_b;
        t2v_r  <= plan.t2_v;
        arg_r  <= plan.arg_index;
      end else if (plan_take) begin
        busy_r <= 1'b0;
      end else if (emit_now) begin
        na_r  <= na_nxt;
        t1v_r <= t1v_nxt;
        nb_r  <= nb_nxt;
        t2v_r <= t2v_nxt;
      end
      if (emit_now) begin
        out_valid_r <= 1'b1;
        out_item_r  <= res;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  a_busy_has_work: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (na_r != '0 || t1v_r || nb_r != '0 || t2v_r))
    else $error("sequencer busy with nothing left to send");

  a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
    (emit_now && !last) |=> busy_r)
    else $error("run dropped before its last result");

  a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
    (emit_now && last && !plan_valid) |=> !busy_r)
    else $error("sequencer stays busy after last result");

endmodule

// File: src/command_line_tokenizer.sv
// command_line_tokenizer: top level of the command line splitter.
// Instantiates clt_parse and clt_emit; depends on clt_pkg.
`timescale 1ns / 1ps

// Splits a command line, fed one byte per item, into argument bytes and
// end-of-argument marks, with a kind-2 result whenever a backslash is
// dropped because the pending count is full. The result sequencer sends one
// result per cycle while out_stall is low; an item with results has 1 to
// MAX_PENDING_BACKSLASHES + 2 of them. Items with no result (blanks between
// arguments, held backslashes, opening quotes) pass without a sequencer run.
// With single-result bytes and no back-pressure the block takes an item every
// cycle. The first result of an item goes through the sequencer load, then
// the output register, before it appears on out_valid.
// in_stall rises while the sequencer still works through a longer run such
// as a flushed backslash run. The line ends only on end_of_line; a zero
// byte is an ordinary byte.
module command_line_tokenizer #(
  parameter int MAX_PENDING_BACKSLASHES = clt_pkg::MAX_PEND_DEF,
  parameter int MAX_ARGUMENTS           = clt_pkg::MAX_ARGS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  // byte items in
  input  logic               in_valid,
  output logic               in_stall,
  input  clt_pkg::in_item_t  in_item,
  // result items out
  output logic               out_valid,
  input  logic               out_stall,
  output clt_pkg::out_item_t out_item
);
  import clt_pkg::*;

  plan_t plan;
  logic  plan_valid;
  logic  plan_take;

  // Parse stage: registers the byte, applies the split rules against the
  // held state and describes the whole run of results for that byte.
  clt_parse #(
    .MAX_PENDING_BACKSLASHES (MAX_PENDING_BACKSLASHES),
    .MAX_ARGUMENTS           (MAX_ARGUMENTS)
  ) u_parse (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .plan_valid (plan_valid),
    .plan       (plan),
    .plan_take  (plan_take)
  );

  // Sequencer: counts the run down, one result a cycle unless stalled, into the
  // output register; takes the next run in the cycle the last result leaves.
  clt_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .plan_valid (plan_valid),
    .plan       (plan),
    .plan_take  (plan_take),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_item   (out_item)
  );

endmodule
